### rtl/bscu_pkg.sv
// bscu_pkg: shared types and constants of the barometric compensation unit
// field widths, register index codes, result ranges and pipeline latency
// no dependencies
`timescale 1ns / 1ps

package bscu_pkg;

  localparam int RAW_W      = 24;
  localparam int CAL_W      = 16;
  localparam int TEMP_OUT_W = 15;
  localparam int PRESS_W    = 17;
  localparam int CFG_IDX_W  = 3;

  // register stages from an accepted item to its result strobe
  localparam int PIPE_LAT = 10;

  localparam int TEMP_REF = 2000;
  localparam int TEMP_LOW = -1500;
  localparam int TEMP_MIN = -4000;
  localparam int TEMP_MAX = 8500;
  localparam int PRESS_MIN = 1000;
  localparam int PRESS_MAX = 120000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_C1_PRESS_SENS    = 3'd0,
    REG_C2_PRESS_OFFSET  = 3'd1,
    REG_C3_SENS_TEMPCO   = 3'd2,
    REG_C4_OFFSET_TEMPCO = 3'd3,
    REG_C5_REF_TEMP      = 3'd4,
    REG_C6_TEMP_SENS     = 3'd5
  } cfg_reg_t;

endpackage

### rtl/baro_sensor_compensation_unit.sv
// baro_sensor_compensation_unit: pipelined second-order pressure/temperature compensation
// depends on bscu_pkg
`timescale 1ns / 1ps

// One item is a raw pressure / raw temperature conversion pair. An item is
// accepted on a rising edge with start high and busy low; busy is low at all
// times outside reset, so a new item can enter on every clock. Its result is
// strobed on out_valid for one cycle, in the order the items were accepted,
// after passing through the ten-stage arithmetic pipeline (offset multiply,
// squares, correction terms, the split 24x39 pressure multiply, final shifts
// and clamp). The result strobe cannot be held off. The six calibration words
// are written through the cfg channel, which is always ready; write them only
// while no item is in flight. Writes to an index above five are dropped.

module baro_sensor_compensation_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // item input
  input  logic                                 start,
  output logic                                 busy,
  input  logic [bscu_pkg::RAW_W-1:0]           in_raw_pressure,
  input  logic [bscu_pkg::RAW_W-1:0]           in_raw_temperature,
  // calibration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bscu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bscu_pkg::CAL_W-1:0]           cfg_data,
  // result strobe
  output logic                                 out_valid,
  output logic signed [bscu_pkg::TEMP_OUT_W-1:0] out_temp_centideg,
  output logic [bscu_pkg::PRESS_W-1:0]         out_press_centimbar,
  output logic                                 out_out_of_range
);

  import bscu_pkg::*;

  // internal widths, each sized to the value range of its quantity
  localparam int DT_W    = RAW_W + 1;        // d2 - c5*256
  localparam int MP_W    = DT_W + CAL_W + 1; // dt times a calibration word
  localparam int SQ_W    = 2 * DT_W;         // dt*dt
  localparam int T2_W    = 18;               // dt*dt >> 31
  localparam int LO_W    = 18;               // temp - 2000
  localparam int TEMP1_W = 19;
  localparam int VL_W    = 19;               // temp + 1500
  localparam int OFF1_W  = 35;
  localparam int SENS1_W = 34;
  localparam int SQR_W   = 35;               // squared temperature deltas
  localparam int OFF2_W  = 38;
  localparam int SENS2_W = 37;
  localparam int TEMP2_W = 20;
  localparam int OFF_W   = 40;
  localparam int SENS_W  = 39;
  localparam int SLO_W   = 20;               // low slice of sens, unsigned
  localparam int SHI_W   = SENS_W - SLO_W;   // high slice of sens, signed
  localparam int PPL_W   = RAW_W + SLO_W;
  localparam int PPH_W   = RAW_W + SHI_W;
  localparam int PROD_W  = RAW_W + SENS_W;
  localparam int DIFF_W  = 43;
  localparam int P_W     = 28;

  // ---------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------
  logic in_fire;

  assign busy      = ~rst_n;
  assign cfg_ready = 1'b1;
  assign in_fire   = start & ~busy;

  // ---------------------------------------------------------------------
  // calibration registers
  // ---------------------------------------------------------------------
  logic [CAL_W-1:0] c1_r, c2_r, c3_r, c4_r, c5_r, c6_r;
  logic [CAL_W-1:0] c1_nxt, c2_nxt, c3_nxt, c4_nxt, c5_nxt, c6_nxt;

  always_comb begin
    c1_nxt = c1_r;
    c2_nxt = c2_r;
    c3_nxt = c3_r;
    c4_nxt = c4_r;
    c5_nxt = c5_r;
    c6_nxt = c6_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_C1_PRESS_SENS:    c1_nxt = cfg_data;
        REG_C2_PRESS_OFFSET:  c2_nxt = cfg_data;
        REG_C3_SENS_TEMPCO:   c3_nxt = cfg_data;
        REG_C4_OFFSET_TEMPCO: c4_nxt = cfg_data;
        REG_C5_REF_TEMP:      c5_nxt = cfg_data;
        REG_C6_TEMP_SENS:     c6_nxt = cfg_data;
        default: ;            // index beyond the register list, dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
      c4_r <= '0;
      c5_r <= '0;
      c6_r <= '0;
    end else begin
      c1_r <= c1_nxt;
      c2_r <= c2_nxt;
      c3_r <= c3_nxt;
      c4_r <= c4_nxt;
      c5_r <= c5_nxt;
      c6_r <= c6_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // valid bits, one per stage, shifting with the data
  // ---------------------------------------------------------------------
  logic [PIPE_LAT-1:0] vld_r, vld_nxt;

  assign vld_nxt = {vld_r[PIPE_LAT-2:0], in_fire};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign out_valid = vld_r[PIPE_LAT-1];

  // ---------------------------------------------------------------------
  // stage 1: temperature difference against the reference
  // ---------------------------------------------------------------------
  logic signed [DT_W-1:0] dt1_r, dt1_nxt;
  logic [RAW_W-1:0]       d1_1_r;

  assign dt1_nxt = $signed(DT_W'(in_raw_temperature)) - $signed(DT_W'({c5_r, 8'h00}));

  // ---------------------------------------------------------------------
  // stage 2: the four products of dt
  // ---------------------------------------------------------------------
  logic signed [MP_W-1:0] mt2_r, mo2_r, ms2_r;
  logic signed [MP_W-1:0] mt2_nxt, mo2_nxt, ms2_nxt;
  logic signed [SQ_W-1:0] sq2;
  logic [T2_W-1:0]        t2_2_r, t2_2_nxt;
  logic [RAW_W-1:0]       d1_2_r;

  assign mt2_nxt  = $signed(MP_W'(dt1_r)) * $signed(MP_W'({1'b0, c6_r}));
  assign mo2_nxt  = $signed(MP_W'(dt1_r)) * $signed(MP_W'({1'b0, c4_r}));
  assign ms2_nxt  = $signed(MP_W'(dt1_r)) * $signed(MP_W'({1'b0, c3_r}));
  assign sq2      = $signed(SQ_W'(dt1_r)) * $signed(SQ_W'(dt1_r));
  // dt*dt is never negative, so the shift by 31 is a plain slice
  assign t2_2_nxt = sq2[31+T2_W-1:31];

  // ---------------------------------------------------------------------
  // stage 3: first-order temperature, offset and sensitivity
  // ---------------------------------------------------------------------
  logic signed [LO_W-1:0]    lo3;
  logic signed [TEMP1_W-1:0] temp1_3_r, temp1_3_nxt;
  logic signed [OFF1_W-1:0]  off1_3_r, off1_3_nxt;
  logic signed [SENS1_W-1:0] sens1_3_r, sens1_3_nxt;
  logic signed [LO_W-1:0]    lo_3_r;
  logic signed [VL_W-1:0]    vl_3_r, vl_3_nxt;
  logic                      lt_3_r, lt_3_nxt;    // below 20 C
  logic                      ltm_3_r, ltm_3_nxt;  // below -15 C
  logic [T2_W-1:0]           t2_3_r;
  logic [RAW_W-1:0]          d1_3_r;

  assign lo3         = LO_W'(mt2_r >>> 23);
  assign temp1_3_nxt = TEMP1_W'(lo3) + TEMP1_W'(TEMP_REF);
  assign vl_3_nxt    = VL_W'(lo3) + VL_W'(TEMP_REF - TEMP_LOW);
  assign off1_3_nxt  = $signed(OFF1_W'({c2_r, 16'h0000})) + OFF1_W'(mo2_r >>> 7);
  assign sens1_3_nxt = $signed(SENS1_W'({c1_r, 15'h0000})) + SENS1_W'(ms2_r >>> 8);
  assign lt_3_nxt    = lo3[LO_W-1];
  assign ltm_3_nxt   = vl_3_nxt[VL_W-1];

  // ---------------------------------------------------------------------
  // stage 4: squares of the low-temperature deltas
  // ---------------------------------------------------------------------
  logic signed [2*LO_W-1:0]  lo_sq4;
  logic signed [2*VL_W-1:0]  vl_sq4;
  logic [SQR_W-1:0]          lo2_4_r, lo2_4_nxt;
  logic [SQR_W-1:0]          vl2_4_r, vl2_4_nxt;
  logic signed [TEMP1_W-1:0] temp1_4_r;
  logic signed [OFF1_W-1:0]  off1_4_r;
  logic signed [SENS1_W-1:0] sens1_4_r;
  logic [T2_W-1:0]           t2_4_r;
  logic                      lt_4_r, ltm_4_r;
  logic [RAW_W-1:0]          d1_4_r;

  assign lo_sq4    = $signed((2*LO_W)'(lo_3_r)) * $signed((2*LO_W)'(lo_3_r));
  assign vl_sq4    = $signed((2*VL_W)'(vl_3_r)) * $signed((2*VL_W)'(vl_3_r));
  assign lo2_4_nxt = lo_sq4[SQR_W-1:0];
  assign vl2_4_nxt = vl_sq4[SQR_W-1:0];

  // ---------------------------------------------------------------------
  // stage 5: second-order terms and corrected temperature
  // ---------------------------------------------------------------------
  logic [OFF2_W-1:0]         lo2w5, vl2w5, lo2x5, vl2x7, vl2x11;
  logic [OFF2_W-1:0]         off2_5_r, off2_5_nxt;
  logic [SENS2_W-1:0]        sens2_5_r, sens2_5_nxt;
  logic signed [TEMP2_W-1:0] temp2_5_r, temp2_5_nxt;
  logic signed [OFF1_W-1:0]  off1_5_r;
  logic signed [SENS1_W-1:0] sens1_5_r;
  logic                      lt_5_r;
  logic [RAW_W-1:0]          d1_5_r;

  assign lo2w5  = OFF2_W'(lo2_4_r);
  assign vl2w5  = OFF2_W'(vl2_4_r);
  assign lo2x5  = (lo2w5 << 2) + lo2w5;
  assign vl2x7  = (vl2w5 << 3) - vl2w5;
  assign vl2x11 = (vl2w5 << 3) + (vl2w5 << 1) + vl2w5;

  // all terms are non-negative, so the shifts need no sign handling
  always_comb begin
    off2_5_nxt  = lo2x5 >> 1;
    sens2_5_nxt = SENS2_W'(lo2x5 >> 2);
    if (ltm_4_r) begin
      off2_5_nxt  = (lo2x5 >> 1) + vl2x7;
      sens2_5_nxt = SENS2_W'((lo2x5 >> 2) + (vl2x11 >> 1));
    end
    temp2_5_nxt = TEMP2_W'(temp1_4_r);
    if (lt_4_r) begin
      temp2_5_nxt = TEMP2_W'(temp1_4_r) - $signed(TEMP2_W'(t2_4_r));
    end
  end

  // ---------------------------------------------------------------------
  // stage 6: corrected offset and sensitivity
  // ---------------------------------------------------------------------
  logic signed [OFF_W-1:0]   off_6_r, off_6_nxt;
  logic signed [SENS_W-1:0]  sens_6_r, sens_6_nxt;
  logic signed [TEMP2_W-1:0] temp_6_r;
  logic [RAW_W-1:0]          d1_6_r;

  always_comb begin
    off_6_nxt  = OFF_W'(off1_5_r);
    sens_6_nxt = SENS_W'(sens1_5_r);
    if (lt_5_r) begin
      off_6_nxt  = OFF_W'(off1_5_r) - $signed(OFF_W'(off2_5_r));
      sens_6_nxt = SENS_W'(sens1_5_r) - $signed(SENS_W'(sens2_5_r));
    end
  end

  // ---------------------------------------------------------------------
  // stage 7: d1*sens as two partial products
  // ---------------------------------------------------------------------
  logic [SLO_W-1:0]         sens_lo7;
  logic signed [SHI_W-1:0]  sens_hi7;
  logic [PPL_W-1:0]         ppl_7_r, ppl_7_nxt;
  logic signed [PPH_W-1:0]  pph_7_r, pph_7_nxt;
  logic signed [OFF_W-1:0]  off_7_r;
  logic signed [TEMP2_W-1:0] temp_7_r;

  assign sens_lo7  = sens_6_r[SLO_W-1:0];
  assign sens_hi7  = sens_6_r[SENS_W-1:SLO_W];
  assign ppl_7_nxt = PPL_W'(d1_6_r) * PPL_W'(sens_lo7);
  assign pph_7_nxt = $signed(PPH_W'({1'b0, d1_6_r})) * $signed(PPH_W'(sens_hi7));

  // ---------------------------------------------------------------------
  // stage 8: recombine the partial products
  // ---------------------------------------------------------------------
  logic signed [PROD_W-1:0]  prod_8_r, prod_8_nxt;
  logic signed [OFF_W-1:0]   off_8_r;
  logic signed [TEMP2_W-1:0] temp_8_r;

  assign prod_8_nxt = (PROD_W'(pph_7_r) <<< SLO_W) + $signed(PROD_W'(ppl_7_r));

  // ---------------------------------------------------------------------
  // stage 9: pressure before clamping
  // ---------------------------------------------------------------------
  logic signed [DIFF_W-1:0]  diff9;
  logic signed [P_W-1:0]     p_9_r, p_9_nxt;
  logic signed [TEMP2_W-1:0] temp_9_r;

  assign diff9   = DIFF_W'(prod_8_r >>> 21) - DIFF_W'(off_8_r);
  assign p_9_nxt = P_W'(diff9 >>> 15);

  // ---------------------------------------------------------------------
  // stage 10: clamp to the rated range, output registers
  // ---------------------------------------------------------------------
  logic signed [TEMP_OUT_W-1:0] temp_out_r, temp_out_nxt;
  logic [PRESS_W-1:0]           press_out_r, press_out_nxt;
  logic                         oor_r, oor_nxt;

  always_comb begin
    temp_out_nxt  = TEMP_OUT_W'(temp_9_r);
    press_out_nxt = PRESS_W'(p_9_r);
    oor_nxt       = 1'b0;
    if (temp_9_r < TEMP2_W'(TEMP_MIN)) begin
      temp_out_nxt = TEMP_OUT_W'(TEMP_MIN);
      oor_nxt      = 1'b1;
    end else if (temp_9_r > TEMP2_W'(TEMP_MAX)) begin
      temp_out_nxt = TEMP_OUT_W'(TEMP_MAX);
      oor_nxt      = 1'b1;
    end
    if (p_9_r < P_W'(PRESS_MIN)) begin
      press_out_nxt = PRESS_W'(PRESS_MIN);
      oor_nxt       = 1'b1;
    end else if (p_9_r > P_W'(PRESS_MAX)) begin
      press_out_nxt = PRESS_W'(PRESS_MAX);
      oor_nxt       = 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // payload registers, no reset: qualified by the valid bits
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    // stage 1
    dt1_r     <= dt1_nxt;
    d1_1_r    <= in_raw_pressure;
    // stage 2
    mt2_r     <= mt2_nxt;
    mo2_r     <= mo2_nxt;
    ms2_r     <= ms2_nxt;
    t2_2_r    <= t2_2_nxt;
    d1_2_r    <= d1_1_r;
    // stage 3
    temp1_3_r <= temp1_3_nxt;
    off1_3_r  <= off1_3_nxt;
    sens1_3_r <= sens1_3_nxt;
    lo_3_r    <= lo3;
    vl_3_r    <= vl_3_nxt;
    lt_3_r    <= lt_3_nxt;
    ltm_3_r   <= ltm_3_nxt;
    t2_3_r    <= t2_2_r;
    d1_3_r    <= d1_2_r;
    // stage 4
    lo2_4_r   <= lo2_4_nxt;
    vl2_4_r   <= vl2_4_nxt;
    temp1_4_r <= temp1_3_r;
    off1_4_r  <= off1_3_r;
    sens1_4_r <= sens1_3_r;
    t2_4_r    <= t2_3_r;
    lt_4_r    <= lt_3_r;
    ltm_4_r   <= ltm_3_r;
    d1_4_r    <= d1_3_r;
    // stage 5
    off2_5_r  <= off2_5_nxt;
    sens2_5_r <= sens2_5_nxt;
    temp2_5_r <= temp2_5_nxt;
    off1_5_r  <= off1_4_r;
    sens1_5_r <= sens1_4_r;
    lt_5_r    <= lt_4_r;
    d1_5_r    <= d1_4_r;
    // stage 6
    off_6_r   <= off_6_nxt;
    sens_6_r  <= sens_6_nxt;
    temp_6_r  <= temp2_5_r;
    d1_6_r    <= d1_5_r;
    // stage 7
    ppl_7_r   <= ppl_7_nxt;
    pph_7_r   <= pph_7_nxt;
    off_7_r   <= off_6_r;
    temp_7_r  <= temp_6_r;
    // stage 8
    prod_8_r  <= prod_8_nxt;
    off_8_r   <= off_7_r;
    temp_8_r  <= temp_7_r;
    // stage 9
    p_9_r     <= p_9_nxt;
    temp_9_r  <= temp_8_r;
    // stage 10
    temp_out_r  <= temp_out_nxt;
    press_out_r <= press_out_nxt;
    oor_r       <= oor_nxt;
  end

  assign out_temp_centideg   = temp_out_r;
  assign out_press_centimbar = press_out_r;
  assign out_out_of_range    = oor_r;

endmodule

### rtl/bscu_checker.sv
// bscu_checker: port-level assertions for baro_sensor_compensation_unit
// depends on bscu_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps

module bscu_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   start,
  input logic                                   busy,
  input logic                                   out_valid,
  input logic signed [bscu_pkg::TEMP_OUT_W-1:0] out_temp_centideg,
  input logic [bscu_pkg::PRESS_W-1:0]           out_press_centimbar,
  input logic                                   out_out_of_range
);

  import bscu_pkg::*;

  // every accepted item is followed by its result strobe
  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_valid)
    else $error("accepted item produced no result strobe");

  // no result strobe without a matching accepted item
  a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LAT))
    else $error("result strobe without an accepted item");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_temp_centideg >= TEMP_OUT_W'(TEMP_MIN)) &&
                  (out_temp_centideg <= TEMP_OUT_W'(TEMP_MAX)))
    else $error("temperature outside rated range");

  a_press_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_press_centimbar >= PRESS_W'(PRESS_MIN)) &&
                  (out_press_centimbar <= PRESS_W'(PRESS_MAX)))
    else $error("pressure outside rated range");

  // a saturated item has at least one result sitting on a range limit
  a_flag_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_range) |->
      (out_temp_centideg == TEMP_OUT_W'(TEMP_MIN)) ||
      (out_temp_centideg == TEMP_OUT_W'(TEMP_MAX)) ||
      (out_press_centimbar == PRESS_W'(PRESS_MIN)) ||
      (out_press_centimbar == PRESS_W'(PRESS_MAX)))
    else $error("range flag set with no result at a limit");

endmodule

bind baro_sensor_compensation_unit bscu_checker u_bscu_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_valid           (out_valid),
  .out_temp_centideg   (out_temp_centideg),
  .out_press_centimbar (out_press_centimbar),
  .out_out_of_range    (out_out_of_range)
);
